[src/gbpc_pkg.sv]
// Package: command codes, pin-to-line table and sizing constants for the GPIO pin controller.
package gbpc_pkg;

  localparam int unsigned NumPinsMax = 32;
  localparam int unsigned NumLines   = 8;
  localparam int unsigned LineRegW   = 8;
  localparam int unsigned SenseW     = 2 * LineRegW;
  localparam int unsigned PinW       = 8;
  localparam int unsigned LineIdxW   = $clog2(LineRegW);
  localparam int unsigned PinIdxW    = $clog2(NumPinsMax);

  localparam logic [7:0] NoLine = 8'hFF;

  typedef enum logic [1:0] {
    FuncConfig = 2'd0,
    FuncRead   = 2'd1,
    FuncWrite  = 2'd2,
    FuncIrq    = 2'd3
  } func_e;

  typedef logic [7:0] line_num_t;

  // External interrupt line of each pin, NoLine where the pin has none.
  localparam line_num_t PinLine [NumPinsMax] = '{
    NoLine, NoLine, 8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd7,
    8'd6,   8'd7,   8'd2,   8'd3,   NoLine, NoLine, NoLine, 8'd1,
    8'd0,   8'd1,   NoLine, NoLine, NoLine, NoLine, 8'd6,   8'd7,
    8'd4,   8'd5,   NoLine, 8'd7,   NoLine, NoLine, 8'd2,   8'd3
  };

  function automatic logic line_valid(line_num_t line);
    line_valid = (32'(line) < NumLines) && (32'(line) < LineRegW);
  endfunction

endpackage

[src/gpio_bridge_pin_controller_top.sv]
// GPIO pin controller: command decode, pin and line registers, result register.
//
// One command beat in, one result beat out. A beat is captured in an input
// register and applied to the pin and line registers by a single layer of
// logic, which also loads the read value and interrupt mask into the result
// register; one command per cycle is sustained while the output side keeps
// taking beats. Pin numbers at or above NUM_PINS leave every register
// unchanged; interrupt setup on pins without a valid line leaves the line
// registers and mux bits unchanged. Pin registers are NUM_PINS bits wide
// and read back zero-extended to 32 bits.
module gpio_bridge_pin_controller_top
  import gbpc_pkg::*;
#(
  parameter int unsigned NUM_PINS = NumPinsMax
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [7:0]  pin_i,
  input  logic        as_output_i,
  input  logic        open_drain_i,
  input  logic        pull_down_i,
  input  logic        pull_up_i,
  input  logic        irq_rise_i,
  input  logic        irq_fall_i,
  input  logic        drive_level_i,
  input  logic [31:0] pin_levels_i,
  input  logic [7:0]  line_flags_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        read_value_o,
  output logic [31:0] pin_irq_mask_o,
  output logic [31:0] dir_bits_o,
  output logic [31:0] out_bits_o,
  output logic [31:0] pull_bits_o,
  output logic [31:0] inen_bits_o,
  output logic [31:0] mux_bits_o,
  output logic [7:0]  line_enable_o,
  output logic [7:0]  line_filter_o,
  output logic [15:0] line_sense_o
);

  typedef logic [NUM_PINS-1:0] pins_t;

  // input register
  logic                in_valid_q;
  func_e               func_q;
  logic [PinW-1:0]     pin_q;
  logic                as_output_q, open_drain_q, pull_down_q, pull_up_q;
  logic                irq_rise_q, irq_fall_q, drive_level_q;
  logic [31:0]         pin_levels_q;
  logic [LineRegW-1:0] line_flags_q;

  // pin and line state
  pins_t dir_q, dir_d, out_q, out_d, pull_q, pull_d;
  pins_t inen_q, inen_d, mux_q, mux_d, od_q, od_d;
  logic [LineRegW-1:0] irq_en_q, irq_en_d, irq_filt_q, irq_filt_d;
  logic [SenseW-1:0]   sense_q, sense_d;

  // result register
  logic        out_valid_q;
  logic        read_value_q;
  logic [31:0] mask_q;

  logic advance;
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  logic                pin_ok;
  pins_t               pbit;
  logic [PinIdxW-1:0]  pidx;
  line_num_t           line;
  logic [LineIdxW-1:0] lidx;
  logic [LineRegW-1:0] lbit;
  logic [SenseW-1:0]   sense_clr, sense_set;
  logic                read_value_d;
  logic [31:0]         mask_d;

  assign pin_ok    = 32'(pin_q) < NUM_PINS;
  assign pidx      = pin_q[PinIdxW-1:0];
  assign pbit      = pin_ok ? (pins_t'(1) << pin_q) : '0;
  assign line      = PinLine[pidx];
  assign lidx      = line[LineIdxW-1:0];
  assign lbit      = LineRegW'(1) << lidx;
  assign sense_clr = SenseW'(3) << {lidx, 1'b0};
  assign sense_set = SenseW'({irq_fall_q, irq_rise_q}) << {lidx, 1'b0};

  always_comb begin
    dir_d        = dir_q;
    out_d        = out_q;
    pull_d       = pull_q;
    inen_d       = inen_q;
    mux_d        = mux_q;
    od_d         = od_q;
    irq_en_d     = irq_en_q;
    irq_filt_d   = irq_filt_q;
    sense_d      = sense_q;
    read_value_d = 1'b0;
    mask_d       = '0;
    case (func_q)
      FuncConfig: begin
        if (pin_ok) begin
          inen_d = inen_q | pbit;
          if (as_output_q) begin
            if (open_drain_q) begin
              od_d   = od_q | pbit;
              pull_d = pull_up_q ? (pull_q | pbit) : (pull_q & ~pbit);
              dir_d  = dir_q & ~pbit;
              out_d  = out_q | pbit;
            end else begin
              od_d   = od_q & ~pbit;
              out_d  = out_q & ~pbit;
              pull_d = pull_q & ~pbit;
              dir_d  = dir_q | pbit;
            end
          end else begin
            dir_d  = dir_q & ~pbit;
            pull_d = (pull_down_q || pull_up_q) ? (pull_q | pbit) : (pull_q & ~pbit);
            // pull-up wins when both are asked for
            if (pull_up_q) begin
              out_d = out_q | pbit;
            end else if (pull_down_q) begin
              out_d = out_q & ~pbit;
            end
            if (line_valid(line)) begin
              if (irq_rise_q || irq_fall_q) begin
                irq_filt_d = irq_filt_q | lbit;
                mux_d      = mux_q | pbit;
                irq_en_d   = irq_en_q | lbit;
              end else begin
                irq_en_d = irq_en_q & ~lbit;
                mux_d    = mux_q & ~pbit;
              end
              sense_d = (sense_q & ~sense_clr) | sense_set;
            end
          end
        end
      end
      FuncRead: begin
        if (pin_ok) begin
          read_value_d = pin_levels_q[pidx];
        end
      end
      FuncWrite: begin
        if (pin_ok) begin
          out_d = drive_level_q ? (out_q | pbit) : (out_q & ~pbit);
          // open drain: high releases the pin, low drives it
          if (|(od_q & pbit)) begin
            dir_d = drive_level_q ? (dir_q & ~pbit) : (dir_q | pbit);
          end
        end
      end
      FuncIrq: begin
        for (int p = 0; p < NUM_PINS; p++) begin
          if (line_valid(PinLine[p])) begin
            mask_d[p] = line_flags_q[PinLine[p][LineIdxW-1:0]];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      dir_q       <= '0;
      out_q       <= '0;
      pull_q      <= '0;
      inen_q      <= '0;
      mux_q       <= '0;
      od_q        <= '0;
      irq_en_q    <= '0;
      irq_filt_q  <= '0;
      sense_q     <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        dir_q      <= dir_d;
        out_q      <= out_d;
        pull_q     <= pull_d;
        inen_q     <= inen_d;
        mux_q      <= mux_d;
        od_q       <= od_d;
        irq_en_q   <= irq_en_d;
        irq_filt_q <= irq_filt_d;
        sense_q    <= sense_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func_q        <= func_e'(func_i);
      pin_q         <= pin_i;
      as_output_q   <= as_output_i;
      open_drain_q  <= open_drain_i;
      pull_down_q   <= pull_down_i;
      pull_up_q     <= pull_up_i;
      irq_rise_q    <= irq_rise_i;
      irq_fall_q    <= irq_fall_i;
      drive_level_q <= drive_level_i;
      pin_levels_q  <= pin_levels_i;
      line_flags_q  <= line_flags_i;
    end
    if (advance) begin
      read_value_q <= read_value_d;
      mask_q       <= mask_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = read_value_q;
  assign pin_irq_mask_o = mask_q;
  assign dir_bits_o     = 32'(dir_q);
  assign out_bits_o     = 32'(out_q);
  assign pull_bits_o    = 32'(pull_q);
  assign inen_bits_o    = 32'(inen_q);
  assign mux_bits_o     = 32'(mux_q);
  assign line_enable_o  = irq_en_q;
  assign line_filter_o  = irq_filt_q;
  assign line_sense_o   = sense_q;

  // a pin routed to the interrupt controller always has its input buffer on
  a_mux_implies_inen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mux_q & ~inen_q) == '0)
    else $error("mux bit set on pin with input buffer off");

  // the filter is never cleared, and is set whenever a line is enabled
  a_enable_implies_filter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (irq_en_q & ~irq_filt_q) == '0)
    else $error("line enabled without filter");

  // a held command is not dropped while the result side stalls
  a_hold_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("pending command lost");

  // pin and line registers move only when a command is applied
  a_state_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(dir_q) && $stable(out_q) && $stable(sense_q) && $stable(od_q))
    else $error("state changed without a command");

  // a result register is loaded only when the previous result is gone
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> !out_valid_q || out_ready_i)
    else $error("result overwritten");

endmodule
